/* rtl/core/bmf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bmf_pkg;

    localparam int BMF_MAX_WIDTH  = 1024;
    localparam int BMF_MAX_HEIGHT = 1024;
    localparam int BMF_MAX_KERNEL = 15;

    localparam int PIX_W   = 8;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 11;
    localparam int FIFO_D  = 8;
    localparam int FIFO_AW = 3;

    localparam logic [PIX_W-1:0] PIX_FG = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BG = 8'd0;

    typedef enum logic [CFG_IW-1:0] {
        CFG_MODE  = 3'd0,
        CFG_KSIZE = 3'd1,
        CFG_KSIZE2 = 3'd2,
        CFG_WIDTH = 3'd3,
        CFG_HEIGHT = 3'd4
    } t_cfg_idx;

    localparam logic [1:0]  RST_MODE   = 2'd0;
    localparam logic [3:0]  RST_KSIZE  = 4'd3;
    localparam logic [3:0]  RST_KSIZE2 = 4'd3;
    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [10:0] RST_HEIGHT = 11'd480;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_out;

endpackage

`default_nettype wire

/* rtl/core/bmf_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_value;
    logic       is_flush;

    modport source (output valid, output pixel_value, output is_flush, input ready);
    modport sink (input valid, input pixel_value, input is_flush, output ready);
endinterface

`default_nettype wire

/* rtl/core/bmf_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic       last_of_frame;

    modport source (output valid, output pixel_out, output last_of_frame, input ready);
    modport sink (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

`default_nettype wire

/* rtl/core/bmf_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

// One square-window stage: a column-history line store plus a horizontal window.
module bmf_stage #(
    parameter int DEPTH = 1024,
    parameter int XW    = 10,
    parameter int WW    = 11,
    parameter int YW    = 11,
    parameter int RW    = 3,
    parameter int HW    = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic          i_bit,
    input  wire logic [XW-1:0] i_xs,
    input  wire logic [YW-1:0] i_ys,
    input  wire logic [XW-1:0] i_px,
    input  wire logic [RW-1:0] i_r,
    input  wire logic [WW-1:0] i_w,
    input  wire logic [YW-1:0] i_h,
    input  wire logic          i_seek,
    output logic               o_hit
);
    localparam int NW = HW + 1;

    logic [HW-1:0] r_mem [DEPTH];
    logic [HW-1:0] r_rdata;
    logic [HW-1:0] r_fwd_data;
    logic          r_fwd_hit;
    logic          r1_valid;
    logic          r1_bit;
    logic [XW-1:0] r1_x;
    logic [YW-1:0] r1_y;
    logic [XW-1:0] r1_px;
    logic [XW-1:0] r2_px;
    logic [NW-1:0] r_hwin;
    logic          r3_hit;

    logic [HW-1:0] hist;
    logic [HW-1:0] n_hist;
    logic [NW-1:0] col;
    logic          col_hit;
    logic          win_hit;

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_rdata <= r_mem[i_xs];
        end
        if (r1_valid) begin
            r_mem[r1_x] <= n_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            // A write to the same column at the read edge is not seen by the read.
            r_fwd_hit  <= r1_valid && (r1_x == i_xs);
            r_fwd_data <= n_hist;
            r1_bit     <= i_bit;
            r1_x       <= i_xs;
            r1_y       <= i_ys;
            r1_px      <= i_px;
        end
        if (r1_valid) begin
            r_hwin <= {r_hwin[NW-2:0], col_hit};
            r2_px  <= r1_px;
        end
        r3_hit <= win_hit;
    end

    always_comb begin
        hist    = r_fwd_hit ? r_fwd_data : r_rdata;
        n_hist  = {hist[HW-2:0], r1_bit};
        col     = {hist, r1_bit};
        col_hit = 1'b0;
        // Entry j of the column is row r1_y - j; rows outside the frame are ignored.
        for (int j = 0; j < NW; j++) begin
            if ((j <= 2 * int'(i_r)) && (int'(r1_y) >= j) && (int'(r1_y) < int'(i_h) + j)
                    && (col[j] == i_seek)) begin
                col_hit = 1'b1;
            end
        end
    end

    always_comb begin
        win_hit = 1'b0;
        // Window slot k holds output column r2_px + r - k.
        for (int k = 0; k < NW; k++) begin
            if ((k <= 2 * int'(i_r)) && (int'(r2_px) + int'(i_r) >= k)
                    && (int'(r2_px) + int'(i_r) - k < int'(i_w)) && r_hwin[k]) begin
                win_hit = 1'b1;
            end
        end
    end

    assign o_hit = r3_hit;

endmodule

`default_nettype wire

/* rtl/core/binary_morphology_filter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// An accepted transaction's pixel passes the stage and tag pipelines into the output queue.
// Throughput: one pixel per cycle unless held off; line stores do a read and a write per cycle.
// A full output queue holds the input off, as does a config write while derived sizes settle.
// Reset is synchronous and active low; it restores the default registers and restarts the frame.
// The line stores need no clearing pass: rows before the frame start are masked by row index.
module binary_morphology_filter_unit #(
    parameter int MAX_WIDTH  = bmf_pkg::BMF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmf_pkg::BMF_MAX_HEIGHT,
    parameter int MAX_KERNEL = bmf_pkg::BMF_MAX_KERNEL
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    bmf_in_if.sink                          i_pix,
    bmf_out_if.source                       o_pix,
    input  wire logic                       i_cfg_we,
    input  wire logic [bmf_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [bmf_pkg::CFG_DW-1:0] i_cfg_data
);
    import bmf_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int YW   = $clog2(MAX_HEIGHT + MAX_KERNEL + 1);
    localparam int RMAX = (MAX_KERNEL - 1) / 2;
    localparam int RW   = $clog2(RMAX + 1);
    localparam int HW   = 2 * RMAX;
    localparam int TW   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_KERNEL * (MAX_WIDTH + 1) + 1);

    // Configuration registers.
    logic [1:0]  r_mode;
    logic [3:0]  r_ks;
    logic [3:0]  r_ks2;
    logic [10:0] r_iw;
    logic [10:0] r_ih;
    logic [1:0]  r_hold;

    // Sizes derived from the registers, settled over the hold-off cycles.
    logic [WW-1:0] r_w;
    logic [YW-1:0] r_h;
    logic [RW-1:0] r_r1;
    logic [RW-1:0] r_r2;
    logic          r_closing;
    logic          r_eroding;
    logic [TW-1:0] r_total;
    logic [TW-1:0] r_d1;
    logic [TW-1:0] r_d2;
    logic [TW-1:0] r_d;
    logic [TW-1:0] r_last_t;

    // Frame position: item count and the raster positions of the three streams.
    logic [TW-1:0] r_t;
    logic [XW-1:0] r_c0x, r_c1x, r_c2x;
    logic [YW-1:0] r_c0y, r_c1y;

    logic [2:0]    r_s2_step;
    logic [XW-1:0] r_s2_xs [3];
    logic [YW-1:0] r_s2_ys [3];
    logic [XW-1:0] r_s2_px [3];
    logic [5:0]    r_emit;
    logic [5:0]    r_last;
    logic [2:0]    r_h1;

    t_out               r_fifo [FIFO_D];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic [FIFO_AW:0]   r_used;

    logic accept, adv, lt_total, past_d1, past_d, is_last, emit, step2, push, pop;
    logic s1_hit, s2_hit;
    logic [PIX_W-1:0] n_pixel;
    int   k1, k2;

    assign accept   = i_pix.valid && i_pix.ready;
    assign lt_total = r_t < r_total;
    assign past_d1  = r_t >= r_d1;
    assign past_d   = r_t >= r_d;
    // A flush before the frame is complete is accepted and ignored.
    assign adv      = accept && !(lt_total && i_pix.is_flush);
    assign is_last  = r_t == r_last_t;
    assign emit     = adv && past_d;
    assign step2    = adv && r_closing && past_d1;
    assign i_pix.ready = (r_hold == 2'd0) && (r_used < (FIFO_AW + 1)'(FIFO_D));

    always_comb begin
        k1 = (int'(r_ks) > MAX_KERNEL) ? MAX_KERNEL : int'(r_ks);
        k2 = (int'(r_ks2) > MAX_KERNEL) ? MAX_KERNEL : int'(r_ks2);
    end

    // Derived sizes; they follow the registers continuously.
    always_ff @(posedge i_clk) begin
        r_w <= (r_iw == 11'd0) ? WW'(1)
             : (int'(r_iw) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_iw);
        r_h <= (r_ih == 11'd0) ? YW'(1)
             : (int'(r_ih) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(r_ih);
        r_closing <= r_mode[1];
        r_eroding <= !r_mode[1] && r_mode[0];
        r_r1 <= (k1 == 0) ? RW'(0) : RW'((k1 - 1) / 2);
        r_r2 <= (!r_mode[1] || k2 == 0) ? RW'(0) : RW'((k2 - 1) / 2);
        r_total  <= TW'(r_w) * TW'(r_h);
        r_d1     <= TW'(r_r1) * TW'(r_w) + TW'(r_r1);
        r_d2     <= TW'(r_r2) * TW'(r_w) + TW'(r_r2);
        r_d      <= r_d1 + r_d2;
        // Built from the same terms as r_d so it settles in the same cycle.
        r_last_t <= r_d1 + r_d2 + r_total - TW'(1);
    end

    // Configuration writes and frame counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= RST_MODE;
            r_ks   <= RST_KSIZE;
            r_ks2  <= RST_KSIZE2;
            r_iw   <= RST_WIDTH;
            r_ih   <= RST_HEIGHT;
            r_hold <= 2'd3;
            r_t    <= '0;
            r_c0x  <= '0;
            r_c0y  <= '0;
            r_c1x  <= '0;
            r_c1y  <= '0;
            r_c2x  <= '0;
        end else if (i_cfg_we && (int'(i_cfg_index) <= int'(CFG_HEIGHT))) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:   r_mode <= i_cfg_data[1:0];
                CFG_KSIZE:  r_ks   <= i_cfg_data[3:0];
                CFG_KSIZE2: r_ks2  <= i_cfg_data[3:0];
                CFG_WIDTH:  r_iw   <= i_cfg_data;
                CFG_HEIGHT: r_ih   <= i_cfg_data;
                default:    r_mode <= r_mode;
            endcase
            // Any register write restarts the frame.
            r_hold <= 2'd3;
            r_t    <= '0;
            r_c0x  <= '0;
            r_c0y  <= '0;
            r_c1x  <= '0;
            r_c1y  <= '0;
            r_c2x  <= '0;
        end else begin
            if (r_hold != 2'd0) begin
                r_hold <= r_hold - 2'd1;
            end
            if (adv && is_last) begin
                r_t   <= '0;
                r_c0x <= '0;
                r_c0y <= '0;
                r_c1x <= '0;
                r_c1y <= '0;
                r_c2x <= '0;
            end else if (adv) begin
                r_t <= r_t + TW'(1);
                if ({1'b0, r_c0x} == WW'(r_w - WW'(1))) begin
                    r_c0x <= '0;
                    r_c0y <= r_c0y + YW'(1);
                end else begin
                    r_c0x <= r_c0x + XW'(1);
                end
                if (past_d1) begin
                    if ({1'b0, r_c1x} == WW'(r_w - WW'(1))) begin
                        r_c1x <= '0;
                        r_c1y <= r_c1y + YW'(1);
                    end else begin
                        r_c1x <= r_c1x + XW'(1);
                    end
                end
                if (past_d) begin
                    r_c2x <= ({1'b0, r_c2x} == WW'(r_w - WW'(1))) ? '0 : r_c2x + XW'(1);
                end
            end
        end
    end

    // First stage: dilate, or erode in erode mode, on the input stream.
    bmf_stage #(
        .DEPTH (MAX_WIDTH), .XW (XW), .WW (WW), .YW (YW), .RW (RW), .HW (HW)
    ) u_stage1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_bit   (lt_total && (i_pix.pixel_value != '0)),
        .i_xs    (r_c0x),
        .i_ys    (r_c0y),
        .i_px    (r_c1x),
        .i_r     (r_r1),
        .i_w     (r_w),
        .i_h     (r_h),
        .i_seek  (!r_eroding),
        .o_hit   (s1_hit)
    );

    // Second stage: the erode of close, fed by the first stage's result.
    bmf_stage #(
        .DEPTH (MAX_WIDTH), .XW (XW), .WW (WW), .YW (YW), .RW (RW), .HW (HW)
    ) u_stage2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_s2_step[2]),
        .i_bit   (s1_hit),
        .i_xs    (r_s2_xs[2]),
        .i_ys    (r_s2_ys[2]),
        .i_px    (r_s2_px[2]),
        .i_r     (r_r2),
        .i_w     (r_w),
        .i_h     (r_h),
        .i_seek  (1'b0),
        .o_hit   (s2_hit)
    );

    // Side pipelines that line up the second stage's step and the result tags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_step <= '0;
            r_emit    <= '0;
        end else begin
            r_s2_step <= {r_s2_step[1:0], step2};
            r_emit    <= {r_emit[4:0], emit};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_xs[0] <= r_c1x;
        r_s2_ys[0] <= r_c1y;
        r_s2_px[0] <= r_c2x;
        for (int i = 1; i < 3; i++) begin
            r_s2_xs[i] <= r_s2_xs[i-1];
            r_s2_ys[i] <= r_s2_ys[i-1];
            r_s2_px[i] <= r_s2_px[i-1];
        end
        r_last <= {r_last[4:0], is_last};
        r_h1   <= {r_h1[1:0], s1_hit};
    end

    always_comb begin
        if (r_closing) begin
            n_pixel = s2_hit ? PIX_BG : PIX_FG;
        end else if (r_eroding) begin
            n_pixel = r_h1[2] ? PIX_BG : PIX_FG;
        end else begin
            n_pixel = r_h1[2] ? PIX_FG : PIX_BG;
        end
    end

    // Output queue; r_used counts results in flight plus queued, so it never overflows.
    assign push = r_emit[5];
    assign pop  = o_pix.valid && o_pix.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= '{pixel: n_pixel, last: r_last[5]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_used <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            r_cnt  <= r_cnt + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
            r_used <= r_used + (FIFO_AW + 1)'(emit) - (FIFO_AW + 1)'(pop);
        end
    end

    assign o_pix.valid         = r_cnt != '0;
    assign o_pix.pixel_out     = r_fifo[r_rp].pixel;
    assign o_pix.last_of_frame = r_fifo[r_rp].last;

endmodule

`default_nettype wire

/* test/binary_morphology_filter_checker.sv */
`timescale 1ns / 1ps

// Watches the pixel channels and the register port and keeps its own image
// copies to predict each filtered pixel.
module binary_morphology_filter_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    bmf_in_if                               in_ch,
    bmf_out_if                              out_ch,
    input  wire logic                       i_cfg_we,
    input  wire logic [bmf_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [bmf_pkg::CFG_DW-1:0] i_cfg_data,
    output int                              o_failures,
    output int                              o_pending
);
    import bmf_pkg::*;

    bit         src_img [BMF_MAX_WIDTH*BMF_MAX_HEIGHT];
    bit         dil_img [BMF_MAX_WIDTH*BMF_MAX_HEIGHT];
    logic [1:0]  cur_mode;
    logic [3:0]  cur_ks;
    logic [3:0]  cur_ks2;
    logic [10:0] cur_w;
    logic [10:0] cur_h;
    int          pos_count;
    t_out        pixel_q[$];

    assign o_pending = pixel_q.size();

    function automatic int clamp_dim(logic [10:0] v, int maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : int'(v);
    endfunction

    function automatic int radius(logic [3:0] k);
        return (k == 0) ? 0 : (int'(k) - 1) / 2;
    endfunction

    // Looks for a pixel equal to seek in the in-frame part of the window.
    function automatic bit window_holds(bit use_dil, int w, int h, int pos, int r, bit seek);
        int cy, cx;
        cy = pos / w;
        cx = pos % w;
        for (int y = cy - r; y <= cy + r; y++) begin
            if (y < 0 || y >= h) continue;
            for (int x = cx - r; x <= cx + r; x++) begin
                if (x < 0 || x >= w) continue;
                if ((use_dil ? dil_img[y*w+x] : src_img[y*w+x]) == seek) return 1;
            end
        end
        return 0;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        o_failures++;
    endtask

    task automatic predict_pixel(logic [7:0] value, logic flush);
        int w, h, total, r1, r2, d1, d, t, p;
        bit closing, eroding;
        t_out res;
        w = clamp_dim(cur_w, BMF_MAX_WIDTH);
        h = clamp_dim(cur_h, BMF_MAX_HEIGHT);
        total = w * h;
        closing = cur_mode[1];
        eroding = !closing && cur_mode[0];
        r1 = radius(cur_ks);
        r2 = closing ? radius(cur_ks2) : 0;
        d1 = r1 * w + r1;
        d = d1 + r2 * w + r2;
        t = pos_count;
        if (t < total) begin
            if (flush) return;
            src_img[t] = (value != 0);
        end
        if (closing && t >= d1 && t - d1 < total)
            dil_img[t-d1] = window_holds(0, w, h, t - d1, r1, 1'b1);
        if (t < d) begin
            pos_count = t + 1;
            return;
        end
        p = t - d;
        if (closing)
            res.pixel = window_holds(1, w, h, p, r2, 1'b0) ? PIX_BG : PIX_FG;
        else if (eroding)
            res.pixel = window_holds(0, w, h, p, r1, 1'b0) ? PIX_BG : PIX_FG;
        else
            res.pixel = window_holds(0, w, h, p, r1, 1'b1) ? PIX_FG : PIX_BG;
        res.last = (p == total - 1);
        pixel_q.push_back(res);
        pos_count = res.last ? 0 : t + 1;
    endtask

    initial o_failures = 0;

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            cur_mode  = RST_MODE;
            cur_ks    = RST_KSIZE;
            cur_ks2   = RST_KSIZE2;
            cur_w     = RST_WIDTH;
            cur_h     = RST_HEIGHT;
            pos_count = 0;
            pixel_q.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pixel_q.size() == 0) begin
                    report_mismatch("pending outputs", 1, 0);
                end else begin
                    want = pixel_q.pop_front();
                    if (out_ch.pixel_out !== want.pixel)
                        report_mismatch("pixel_out", out_ch.pixel_out, want.pixel);
                    if (out_ch.last_of_frame !== want.last)
                        report_mismatch("last_of_frame", out_ch.last_of_frame, want.last);
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_pixel(in_ch.pixel_value, in_ch.is_flush);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:   begin cur_mode = i_cfg_data[1:0]; pos_count = 0; end
                    CFG_KSIZE:  begin cur_ks   = i_cfg_data[3:0]; pos_count = 0; end
                    CFG_KSIZE2: begin cur_ks2  = i_cfg_data[3:0]; pos_count = 0; end
                    CFG_WIDTH:  begin cur_w    = i_cfg_data;      pos_count = 0; end
                    CFG_HEIGHT: begin cur_h    = i_cfg_data;      pos_count = 0; end
                    default: ;
                endcase
            end
        end
    end

endmodule

/* test/binary_morphology_filter_unit_test.sv */
`timescale 1ns / 1ps

// Top of the morphology filter bench. It drives whole frames through the
// block, each followed by the drain transactions that bring out the delayed
// outputs, and leaves prediction and comparison to the checker.
module binary_morphology_filter_unit_test;
    import bmf_pkg::*;

    // Generous bound on the whole run, in clock cycles.
    localparam int CYCLE_LIMIT = 1000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    int                failures;
    int                pending;
    int                cycles;
    int                frames_done;
    int                items_sent;
    bit                no_idle;

    bmf_in_if  pix_in();
    bmf_out_if pix_out();

    binary_morphology_filter_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_in),
        .o_pix       (pix_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    binary_morphology_filter_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (pix_in),
        .out_ch      (pix_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    // A 20 ns clock.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The watchdog ends a run that goes on past the bound above and reports it as failed.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // The output side stalls for a random number of cycles before each
    // transaction, except during the stretches where idling is turned off.
    initial begin
        int stall;
        pix_out.ready = 1'b0;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                @(negedge i_clk);
                pix_out.ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            pix_out.ready = 1'b1;
            do @(posedge i_clk); while (!pix_out.valid);
        end
    end

    // Sends one input transaction after a random gap and waits for it to be
    // taken. Valid stays high into the next item when there is no gap.
    task automatic send_item(logic [7:0] value, logic flush);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            pix_in.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_in.valid       = 1'b1;
        pix_in.pixel_value = value;
        pix_in.is_flush    = flush;
        do @(posedge i_clk); while (!pix_in.ready);
        items_sent++;
    endtask

    // Waits until every predicted pixel has come out, then lets the pipeline
    // settle so that trailing transactions with no output are done too.
    task automatic drain_outputs();
        @(negedge i_clk);
        pix_in.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DW-1:0] value);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
    endtask

    // Writes all five registers while the block is idle.
    task automatic configure(logic [1:0] mode, logic [3:0] ks, logic [3:0] ks2,
                             logic [10:0] w, logic [10:0] h);
        drain_outputs();
        write_reg(CFG_MODE, CFG_DW'(mode));
        write_reg(CFG_KSIZE, CFG_DW'(ks));
        write_reg(CFG_KSIZE2, CFG_DW'(ks2));
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] random_pixel();
        case ($urandom_range(0, 7))
            0, 1, 2: return 8'd0;
            3:       return 8'd255;
            4:       return 8'd1;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Streams one frame: its pixels with an occasional flush inside the frame,
    // which must be ignored, then enough drain transactions to bring out the
    // last pixel. Some drain transactions carry a pixel, which acts as flush.
    task automatic run_frame(logic [1:0] mode, logic [3:0] ks, logic [3:0] ks2,
                             logic [10:0] w, logic [10:0] h);
        int weff, heff, r1, r2, delay;
        weff = (w == 0) ? 1 : (w > BMF_MAX_WIDTH) ? BMF_MAX_WIDTH : int'(w);
        heff = (h == 0) ? 1 : (h > BMF_MAX_HEIGHT) ? BMF_MAX_HEIGHT : int'(h);
        r1 = (ks == 0) ? 0 : (int'(ks) - 1) / 2;
        r2 = !mode[1] ? 0 : (ks2 == 0) ? 0 : (int'(ks2) - 1) / 2;
        delay = (r1 + r2) * weff + r1 + r2;
        configure(mode, ks, ks2, w, h);
        for (int i = 0; i < weff * heff; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_item(random_pixel(), 1'b1);
            send_item(random_pixel(), 1'b0);
        end
        for (int i = 0; i < delay; i++)
            send_item(random_pixel(), $urandom_range(0, 7) != 0);
        frames_done++;
    endtask

    initial begin
        logic [10:0] rw, rh;
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_MODE;
        cfg_data           = '0;
        pix_in.valid       = 1'b0;
        pix_in.pixel_value = '0;
        pix_in.is_flush    = 1'b0;
        no_idle            = 1'b0;
        frames_done        = 0;
        items_sent         = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames: each operation, mode three acting as close, even
        // and zero kernel sizes, the largest kernel, and zero frame sizes.
        run_frame(2'd0, 4'd3, 4'd3, 11'd5, 11'd4);
        run_frame(2'd1, 4'd3, 4'd3, 11'd5, 11'd4);
        run_frame(2'd2, 4'd3, 4'd5, 11'd6, 11'd5);
        run_frame(2'd3, 4'd2, 4'd4, 11'd4, 11'd4);
        run_frame(2'd1, 4'd0, 4'd0, 11'd3, 11'd3);
        run_frame(2'd1, 4'd15, 4'd1, 11'd3, 11'd3);
        run_frame(2'd0, 4'd1, 4'd15, 11'd0, 11'd0);

        // A write to an index past the register list must change nothing.
        drain_outputs();
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = CFG_IW'(5);
        cfg_data  = 11'h7ff;
        @(negedge i_clk);
        cfg_index = CFG_IW'(7);
        @(negedge i_clk);
        cfg_we = 1'b0;
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);

        no_idle = 1'b1;
        run_frame(2'd0, 4'd3, 4'd3, 11'd12, 11'd6);
        no_idle = 1'b0;
        run_frame(2'd2, 4'd15, 4'd15, 11'd1, 11'd40);

        // Random frames of small size.
        while (items_sent < 1050) begin
            no_idle = ($urandom_range(0, 5) == 0);
            rw = 11'($urandom_range(1, 12));
            rh = 11'($urandom_range(1, 10));
            run_frame(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), rw, rh);
        end
        no_idle = 1'b0;

        drain_outputs();
        repeat (20) @(negedge i_clk);
        $display("covered %0d frames in all modes with %0d input transactions",
                 frames_done, items_sent);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* binary_morphology_filter_unit.f */
rtl/core/bmf_pkg.sv
rtl/core/bmf_in_if.sv
rtl/core/bmf_out_if.sv
rtl/core/bmf_stage.sv
rtl/core/binary_morphology_filter_unit.sv
test/binary_morphology_filter_checker.sv
test/binary_morphology_filter_unit_test.sv
